// File: design/tid_pkg.sv
// Shared types, telnet byte codes and queue sizing for the IAC deframer.
package tid_pkg;

    // Telnet command bytes
    localparam logic [7:0] TN_IAC  = 8'd255;
    localparam logic [7:0] TN_DONT = 8'd254;
    localparam logic [7:0] TN_DO   = 8'd253;
    localparam logic [7:0] TN_WONT = 8'd252;
    localparam logic [7:0] TN_WILL = 8'd251;
    localparam logic [7:0] TN_SB   = 8'd250;
    localparam logic [7:0] TN_SE   = 8'd240;

    // Event queue between parser and output stage (power of two)
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        ST_DATA   = 3'd0,
        ST_IAC    = 3'd1,
        ST_OPT    = 3'd2,
        ST_SBTYPE = 3'd3,
        ST_SBDATA = 3'd4,
        ST_SBIAC  = 3'd5
    } t_parse_state;

    typedef enum logic [2:0] {
        K_DATA   = 3'd0,
        K_NEG    = 3'd1,
        K_CMD    = 3'd2,
        K_SBBYTE = 3'd3,
        K_SBEND  = 3'd4,
        K_SBABRT = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] command;
        logic [7:0] option_code;
        logic [7:0] payload;
        logic       last;
    } t_event;

    // Handshake between queue and output stage
    typedef struct packed {
        logic not_empty;
        logic full;
    } t_queue_status;

endpackage

// File: design/tid_front.sv
// Front end: takes received bytes, runs the IAC parser and classifies events.
module tid_front
    import tid_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_rx_byte,
    input  logic       i_full,
    output logic       o_stall,
    output logic       o_push,
    output t_event     o_event
);

    t_parse_state r_state, n_state;
    logic [7:0]   r_held, n_held;
    logic [7:0]   r_subneg, n_subneg;
    logic         w_accept;
    logic         w_is_neg;

    assign o_stall  = i_full;
    assign w_accept = i_valid && !i_full;
    assign w_is_neg = (i_rx_byte == TN_WILL) || (i_rx_byte == TN_WONT) ||
                      (i_rx_byte == TN_DO)   || (i_rx_byte == TN_DONT);

    // Next state and held bytes
    always_comb begin
        n_state  = r_state;
        n_held   = r_held;
        n_subneg = r_subneg;
        if (w_accept) begin
            unique case (r_state)
                ST_IAC: begin
                    if (i_rx_byte == TN_IAC) begin
                        n_state = ST_DATA;
                    end else if (w_is_neg) begin
                        n_held  = i_rx_byte;
                        n_state = ST_OPT;
                    end else if (i_rx_byte == TN_SB) begin
                        n_state = ST_SBTYPE;
                    end else begin
                        n_state = ST_DATA;
                    end
                end
                ST_OPT: n_state = ST_DATA;
                ST_SBTYPE: begin
                    n_subneg = i_rx_byte;
                    n_state  = ST_SBDATA;
                end
                ST_SBDATA: begin
                    if (i_rx_byte == TN_IAC) n_state = ST_SBIAC;
                end
                ST_SBIAC: begin
                    n_state = (i_rx_byte == TN_IAC) ? ST_SBDATA : ST_DATA;
                end
                // plain data, unused codes included
                default: begin
                    n_state = (i_rx_byte == TN_IAC) ? ST_IAC : ST_DATA;
                end
            endcase
        end
    end

    // Event produced by the accepted byte
    always_comb begin
        o_push  = 1'b0;
        o_event = '{kind: K_DATA, command: 8'd0, option_code: 8'd0,
                    payload: 8'd0, last: 1'b0};
        if (w_accept) begin
            unique case (r_state)
                ST_IAC: begin
                    if (i_rx_byte == TN_IAC) begin
                        o_push          = 1'b1;
                        o_event.payload = i_rx_byte;
                    end else if (!w_is_neg && i_rx_byte != TN_SB) begin
                        o_push          = 1'b1;
                        o_event.kind    = K_CMD;
                        o_event.command = i_rx_byte;
                    end
                end
                ST_OPT: begin
                    o_push              = 1'b1;
                    o_event.kind        = K_NEG;
                    o_event.command     = r_held;
                    o_event.option_code = i_rx_byte;
                end
                ST_SBTYPE: o_push = 1'b0;
                ST_SBDATA: begin
                    if (i_rx_byte != TN_IAC) begin
                        o_push              = 1'b1;
                        o_event.kind        = K_SBBYTE;
                        o_event.option_code = r_subneg;
                        o_event.payload     = i_rx_byte;
                    end
                end
                ST_SBIAC: begin
                    o_push              = 1'b1;
                    o_event.option_code = r_subneg;
                    if (i_rx_byte == TN_IAC) begin
                        o_event.kind    = K_SBBYTE;
                        o_event.payload = i_rx_byte;
                    end else if (i_rx_byte == TN_SE) begin
                        o_event.kind = K_SBEND;
                        o_event.last = 1'b1;
                    end else begin
                        o_event.kind = K_SBABRT;
                    end
                end
                default: begin
                    if (i_rx_byte != TN_IAC) begin
                        o_push          = 1'b1;
                        o_event.payload = i_rx_byte;
                    end
                end
            endcase
        end
    end

    // Parser registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_DATA;
            r_held   <= 8'd0;
            r_subneg <= 8'd0;
        end else begin
            r_state  <= n_state;
            r_held   <= n_held;
            r_subneg <= n_subneg;
        end
    end

    // An option byte always closes a negotiation
    a_opt_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_state == ST_OPT) |=> (r_state == ST_DATA))
        else $error("parser did not return to data after option byte");

    // Type byte is captured for the run
    a_type_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_state == ST_SBTYPE) |=> (r_subneg == $past(i_rx_byte)))
        else $error("subnegotiation type not captured");

    // Last marker only on a subnegotiation end
    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_event.last == (o_event.kind == K_SBEND)))
        else $error("last marker out of place");

endmodule

// File: design/tid_queue.sv
// Short event queue decoupling the parser from the output stage.
module tid_queue
    import tid_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_event        i_event,
    input  logic          i_pop,
    output t_event        o_event,
    output t_queue_status o_status
);

    t_event           r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr;
    logic [QCW-1:0]   r_count;

    assign o_status.not_empty = (r_count != '0);
    assign o_status.full      = (r_count == QCW'(QDEPTH));
    assign o_event            = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_event;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            priority if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end else begin
                r_count <= r_count;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.full |-> !i_push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_status.not_empty)
        else $error("pop from empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCW'(QDEPTH))
        else $error("queue count out of range");

endmodule

// File: design/tid_back.sv
// Back end: output register that presents events and holds them under stall.
module tid_back
    import tid_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_queue_status i_status,
    input  t_event        i_event,
    input  logic          i_stall,
    output logic          o_pop,
    output logic          o_valid,
    output t_event        o_event
);

    logic   r_valid;
    t_event r_event;

    // Load when the register is empty or its transfer completes
    assign o_pop   = i_status.not_empty && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_event = r_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_stall) begin
            r_valid <= i_status.not_empty;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (o_pop) r_event <= i_event;
    end

endmodule

// File: design/telnet_iac_deframer_unit.sv
// Top level of the telnet IAC deframer: parser, event queue and output stage.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------
//  rx      | in        | i_valid / o_stall    | i_rx_byte[7:0]
//  event   | out       | o_valid / i_stall    | o_kind, o_command, o_option_code,
//          |           |                      | o_payload, o_last
//
//  One byte per cycle while o_stall is low; a byte gives zero or one event.
//  After the byte transfer, an event goes through the queue write, then the output register.
//  The parser takes a byte whenever the two-entry event queue is not full.
//  Reset (i_rst_n low, synchronous) empties the queue and returns the parser to data.
//  Stall on the output fills the queue, then stalls the input.
module telnet_iac_deframer_unit
    import tid_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_kind,
    output logic [7:0] o_command,
    output logic [7:0] o_option_code,
    output logic [7:0] o_payload,
    output logic       o_last
);

    logic          w_push;
    logic          w_pop;
    t_event        w_front_event;
    t_event        w_queue_event;
    t_event        w_out_event;
    t_queue_status w_status;

    tid_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_rx_byte (i_rx_byte),
        .i_full    (w_status.full),
        .o_stall   (o_stall),
        .o_push    (w_push),
        .o_event   (w_front_event)
    );

    tid_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_event  (w_front_event),
        .i_pop    (w_pop),
        .o_event  (w_queue_event),
        .o_status (w_status)
    );

    tid_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .i_event  (w_queue_event),
        .i_stall  (i_stall),
        .o_pop    (w_pop),
        .o_valid  (o_valid),
        .o_event  (w_out_event)
    );

    assign o_kind        = w_out_event.kind;
    assign o_command     = w_out_event.command;
    assign o_option_code = w_out_event.option_code;
    assign o_payload     = w_out_event.payload;
    assign o_last        = w_out_event.last;

endmodule
